// ===== src/hcbd_pkg.sv =====
// ============================================================================
// hcbd_pkg - chunked body decoder shared definitions
// Types, character codes and size constants used by the decoder.
// ============================================================================
`default_nettype none

package hcbd_pkg;

	// Length limit of a size line, in bytes that are not CR
	localparam int LINE_LIMIT = 23;
	// Width of the chunk size accumulator and the payload down-counter
	localparam int SIZE_BITS  = 32;
	// Width of the size line byte counter
	localparam int LC_W       = $clog2(LINE_LIMIT + 1);

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;

	typedef enum logic [2:0] {
		PH_SIZE,
		PH_DATA,
		PH_CR,
		PH_LF,
		PH_STOP
	} phase_t;

	typedef enum logic [2:0] {
		LX_LEAD,
		LX_SIGNED,
		LX_ZERO,
		LX_PREFIX,
		LX_DIGITS,
		LX_END,
		LX_NEG
	} lex_t;

	typedef enum logic [2:0] {
		ST_RUN  = 3'd0,
		ST_DONE = 3'd1,
		ST_BAD  = 3'd2,
		ST_LONG = 3'd3,
		ST_CRLF = 3'd4
	} stat_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	// Decode one ASCII hex digit; ok is low for any other character
	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		case (c) inside
			[8'h30:8'h39]: h.val = c[3:0];
			[8'h61:8'h66]: h.val = 4'(c[3:0] + 4'd9);
			[8'h41:8'h46]: h.val = 4'(c[3:0] + 4'd9);
			default:       h.ok  = 1'b0;
		endcase
		return h;
	endfunction

endpackage

`default_nettype wire

// ===== src/http_chunked_body_decoder.sv =====
// ============================================================================
// http_chunked_body_decoder - HTTP/1.1 chunked transfer body decoder
// Parses hex size lines, passes chunk payload bytes on, checks the CR LF
// after each chunk and reports finish or error through a sticky status.
// ============================================================================
// Pipeline: a received byte lands in the input register at the edge that
// accepts it; its result then moves into the result register, which
// drives the outputs.
// Throughput: one byte per cycle while the result channel is not stalled; the
// per-byte size shift-and-add or the payload down-count fits between the two registers.
// Reset: arst_n clears the decoder to the start of a size line with status
// running; the pipeline comes up empty.
`default_nettype none

module http_chunked_body_decoder import hcbd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// received byte channel
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	// decoded result channel
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      payload_byte,
	output logic            payload_valid,
	output logic            chunk_last,
	output logic [2:0]      status
);

	// ------------------------------------------------------------------
	// Pipeline control
	// ------------------------------------------------------------------
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_s2;
	logic       out_load;
	logic       adv;

	// The result register takes a new transaction when empty or draining.
	assign out_load = !out_valid_s2 || !out_stall;
	// The decoder state moves only when the input register hands its byte on.
	assign adv      = valid_s1 && out_load;
	// Hold the input register only while it is full and cannot advance.
	assign in_stall = valid_s1 && !out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// ------------------------------------------------------------------
	// Decoder state
	// ------------------------------------------------------------------
	phase_t                 phase_q,  phase_d;
	lex_t                   lex_q,    lex_d;
	stat_t                  stat_q,   stat_d;
	logic [LC_W-1:0]        line_count_q, line_count_d;
	logic                   digits_q, digits_d;
	logic [SIZE_BITS-1:0]   accum_q,  accum_d;
	logic [SIZE_BITS-1:0]   left_q,   left_d;

	logic                   pv_d;
	logic                   last_d;
	logic [7:0]             pb_d;

	// Lexer helpers
	hex_t                   hx;
	logic                   is_blank;
	logic                   do_signed;
	logic [LC_W-1:0]        lc_next;
	logic [SIZE_BITS-1:0]   left_dec;
	logic [SIZE_BITS-1:0]   accum_add;

	assign hx       = hex_decode(byte_s1);
	assign is_blank = byte_s1 inside {CH_SP, CH_TAB, CH_VT, CH_FF};
	assign lc_next  = LC_W'(line_count_q + 1'b1);
	assign left_dec = (left_q != '0) ? SIZE_BITS'(left_q - 1'b1) : left_q;

	// Saturate once any of the top digit bits would be shifted out.
	assign accum_add = (accum_q[SIZE_BITS-1 -: 4] != 4'd0) ? '1
		: {accum_q[SIZE_BITS-5:0], hx.val};

	// Sign position: leading blank state past blanks and sign, or right after a plus
	assign do_signed = (lex_q == LX_SIGNED) ||
		(lex_q == LX_LEAD && !is_blank && byte_s1 != CH_PLUS && byte_s1 != CH_MINUS);

	always_comb begin
		phase_d      = phase_q;
		lex_d        = lex_q;
		stat_d       = stat_q;
		line_count_d = line_count_q;
		digits_d     = digits_q;
		accum_d      = accum_q;
		left_d       = left_q;
		pv_d         = 1'b0;
		last_d       = 1'b0;
		pb_d         = 8'd0;

		case (phase_q)
			PH_SIZE: begin
				if (byte_s1 == CH_LF) begin
					if (lex_q == LX_NEG || !digits_q) begin
						stat_d  = ST_BAD;
						phase_d = PH_STOP;
					end else if (accum_q == '0) begin
						stat_d  = ST_DONE;
						phase_d = PH_STOP;
					end else begin
						left_d  = accum_q;
						phase_d = PH_DATA;
					end
				end else if (byte_s1 != CH_CR) begin
					line_count_d = lc_next;
					if (lc_next >= LC_W'(LINE_LIMIT)) begin
						stat_d  = ST_LONG;
						phase_d = PH_STOP;
					end else if (lex_q == LX_LEAD && is_blank) begin
						// skip leading blanks
					end else if (lex_q == LX_LEAD && byte_s1 == CH_PLUS) begin
						lex_d = LX_SIGNED;
					end else if (lex_q == LX_LEAD && byte_s1 == CH_MINUS) begin
						lex_d = LX_NEG;
					end else if (do_signed && byte_s1 == CH_ZERO) begin
						// a leading zero may open a 0x prefix
						digits_d = 1'b1;
						accum_d  = '0;
						lex_d    = LX_ZERO;
					end else if (lex_q == LX_ZERO &&
						(byte_s1 == CH_X_LO || byte_s1 == CH_X_UP)) begin
						lex_d = LX_PREFIX;
					end else if (do_signed || lex_q == LX_ZERO ||
						lex_q == LX_PREFIX || lex_q == LX_DIGITS) begin
						if (hx.ok) begin
							digits_d = 1'b1;
							accum_d  = accum_add;
							lex_d    = LX_DIGITS;
						end else begin
							lex_d = LX_END;
						end
					end
				end
			end
			PH_DATA: begin
				pv_d   = 1'b1;
				pb_d   = byte_s1;
				left_d = left_dec;
				if (left_dec == '0) begin
					last_d  = 1'b1;
					phase_d = PH_CR;
				end
			end
			PH_CR: begin
				if (byte_s1 == CH_CR) begin
					phase_d = PH_LF;
				end else begin
					stat_d  = ST_CRLF;
					phase_d = PH_STOP;
				end
			end
			PH_LF: begin
				if (byte_s1 == CH_LF) begin
					// start the next size line
					phase_d      = PH_SIZE;
					lex_d        = LX_LEAD;
					line_count_d = '0;
					digits_d     = 1'b0;
					accum_d      = '0;
				end else begin
					stat_d  = ST_CRLF;
					phase_d = PH_STOP;
				end
			end
			default: begin
				// finished or failed: drop every further byte
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SIZE;
			lex_q        <= LX_LEAD;
			stat_q       <= ST_RUN;
			line_count_q <= '0;
			digits_q     <= 1'b0;
			accum_q      <= '0;
			left_q       <= '0;
		end else if (adv) begin
			phase_q      <= phase_d;
			lex_q        <= lex_d;
			stat_q       <= stat_d;
			line_count_q <= line_count_d;
			digits_q     <= digits_d;
			accum_q      <= accum_d;
			left_q       <= left_d;
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	logic [7:0] pb_s2;
	logic       pv_s2;
	logic       last_s2;
	stat_t      stat_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (out_load) begin
			out_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pb_s2   <= pb_d;
			pv_s2   <= pv_d;
			last_s2 <= last_d;
			stat_s2 <= stat_d;
		end
	end

	assign out_valid     = out_valid_s2;
	assign payload_byte  = pb_s2;
	assign payload_valid = pv_s2;
	assign chunk_last    = last_s2;
	assign status        = stat_s2;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_payload_running: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && pv_s2 |-> stat_s2 == ST_RUN)
		else $error("payload byte delivered with a final status");

	a_last_is_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && last_s2 |-> pv_s2)
		else $error("chunk_last without payload_valid");

	a_status_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stat_q != ST_RUN |=> stat_q == $past(stat_q))
		else $error("sticky status changed");

	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> left_q != '0)
		else $error("payload phase with nothing left to pass");

	a_stop_status: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_STOP) == (stat_q != ST_RUN))
		else $error("stop phase and status disagree");

endmodule

`default_nettype wire

// ===== dv/http_chunked_body_decoder_tb.sv =====
// ============================================================================
// http_chunked_body_decoder_tb - self-checking bench for the chunk decoder
// Feeds one chunked body byte by byte through the valid/stall input channel,
// predicts every result with a behavioral decoder kept inside the bench and
// compares each result transaction field by field in arrival order.
// The body is one long run of well-formed chunks with randomized size line
// formatting. It ends in one of several finishing or error cases, picked at
// random per seed, because finish and errors are sticky and reset is applied
// only once.
// ============================================================================

module http_chunked_body_decoder_tb;
	import hcbd_pkg::*;

	// accepted-byte counts where the idling pattern changes
	localparam int PHASE_B      = 160;
	localparam int PHASE_C      = 320;
	// bytes to generate before the closing case is appended
	localparam int BODY_BYTES   = 440;
	// receiver hold-off long enough to back the decoder up into its input
	localparam int LONG_HOLD    = 90;
	// quiet cycles after the last result
	localparam int DRAIN_CYCLES = 8;
	localparam int TIMEOUT_TIME = 2_000_000;

	// how the body is closed; only one of these can happen per run
	typedef enum int {
		END_ZERO_SIZE,
		END_PREFIX_ONLY,
		END_MINUS_SIGN,
		END_NO_DIGITS,
		END_BLANK_AFTER_SIGN,
		END_LONG_LINE,
		END_BAD_TRAILER,
		END_OVERFLOW
	} body_end_t;
	localparam int N_BODY_ENDS = 8;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       last;
		logic [2:0] status;
	} decoded_t;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       in_valid      = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte       = 8'h00;
	logic       out_valid;
	logic       out_stall     = 1'b0;
	logic [7:0] payload_byte;
	logic       payload_valid;
	logic       chunk_last;
	logic [2:0] status;

	http_chunked_body_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.payload_byte (payload_byte),
		.payload_valid(payload_valid),
		.chunk_last   (chunk_last),
		.status       (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bytes still to be offered, and results predicted but not yet seen
	logic [7:0] rx_pending[$];
	logic [7:0] line_buf[$];
	decoded_t   predicted_out[$];

	int        sent_count    = 0;
	int        results_seen  = 0;
	int        error_count   = 0;
	int        payload_total = 0;
	int        chunk_total   = 0;
	int        hold_left     = 0;
	bit        hold_done     = 1'b0;
	body_end_t body_end      = END_ZERO_SIZE;

	// ------------------------------------------------------------------------
	// Behavioral decoder state, at its reset values
	// ------------------------------------------------------------------------
	phase_t               chunk_phase = PH_SIZE;
	lex_t                 lex_step    = LX_LEAD;
	logic [LC_W-1:0]      line_len    = '0;
	bit                   saw_digit   = 1'b0;
	logic [SIZE_BITS-1:0] size_acc    = '0;
	logic [SIZE_BITS-1:0] remaining   = '0;
	stat_t                body_status = ST_RUN;

	// Return the value of a hex digit, or 16 for anything else (NUL included)
	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return int'(c - "0");
		if (c >= "a" && c <= "f")
			return int'(c - "a") + 10;
		if (c >= "A" && c <= "F")
			return int'(c - "A") + 10;
		return 16;
	endfunction

	// Shift one digit into the size; pin it at all ones once it would overflow
	function automatic void push_nibble(input int d);
		saw_digit = 1'b1;
		if (size_acc > ({SIZE_BITS{1'b1}} >> 4))
			size_acc = '1;
		else
			size_acc = {size_acc[SIZE_BITS-5:0], 4'(d)};
		lex_step = LX_DIGITS;
	endfunction

	// Advance the decoder by one received byte and return the result it gives
	function automatic decoded_t decode_rx_byte(input logic [7:0] c);
		decoded_t r;
		int       d;
		r.data  = 8'h00;
		r.valid = 1'b0;
		r.last  = 1'b0;
		d       = hex_nibble(c);
		case (chunk_phase)
			PH_SIZE: begin
				if (c == CH_LF) begin
					// close the size line: minus or no digit is a bad line, zero finishes
					if (lex_step == LX_NEG || !saw_digit) begin
						body_status = ST_BAD;
						chunk_phase = PH_STOP;
					end else if (size_acc == '0) begin
						body_status = ST_DONE;
						chunk_phase = PH_STOP;
					end else begin
						remaining   = size_acc;
						chunk_phase = PH_DATA;
					end
				end else if (c != CH_CR) begin
					line_len++;
					if (line_len >= LINE_LIMIT) begin
						body_status = ST_LONG;
						chunk_phase = PH_STOP;
					end else begin
						// lex the size the way strtoul base 16 does
						case (lex_step)
							LX_LEAD, LX_SIGNED: begin
								if (lex_step == LX_LEAD && (c == CH_SP || c == CH_TAB ||
										c == CH_VT || c == CH_FF)) begin
									// skip leading blanks
								end else if (lex_step == LX_LEAD && c == CH_PLUS) begin
									lex_step = LX_SIGNED;
								end else if (lex_step == LX_LEAD && c == CH_MINUS) begin
									lex_step = LX_NEG;
								end else if (c == CH_ZERO) begin
									saw_digit = 1'b1;
									size_acc  = '0;
									lex_step  = LX_ZERO;
								end else if (d < 16) begin
									push_nibble(d);
								end else begin
									lex_step = LX_END;
								end
							end
							LX_ZERO: begin
								if (c == CH_X_LO || c == CH_X_UP)
									lex_step = LX_PREFIX;
								else if (d < 16)
									push_nibble(d);
								else
									lex_step = LX_END;
							end
							LX_PREFIX, LX_DIGITS: begin
								if (d < 16)
									push_nibble(d);
								else
									lex_step = LX_END;
							end
							default: begin
							end
						endcase
					end
				end
			end
			PH_DATA: begin
				r.valid = 1'b1;
				r.data  = c;
				if (remaining != '0)
					remaining--;
				if (remaining == '0) begin
					r.last      = 1'b1;
					chunk_phase = PH_CR;
				end
			end
			PH_CR: begin
				if (c == CH_CR) begin
					chunk_phase = PH_LF;
				end else begin
					body_status = ST_CRLF;
					chunk_phase = PH_STOP;
				end
			end
			PH_LF: begin
				if (c == CH_LF) begin
					// start the next size line
					chunk_phase = PH_SIZE;
					line_len    = '0;
					lex_step    = LX_LEAD;
					saw_digit   = 1'b0;
					size_acc    = '0;
				end else begin
					body_status = ST_CRLF;
					chunk_phase = PH_STOP;
				end
			end
			default: begin
			end
		endcase
		r.status = body_status;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Body generation helpers
	// ------------------------------------------------------------------------
	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
		if (n < 4'd10)
			return 8'(CH_ZERO + n);
		return 8'((upper ? "A" : "a") + n - 4'd10);
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 3))
			0:       return CH_SP;
			1:       return CH_TAB;
			2:       return CH_VT;
			default: return CH_FF;
		endcase
	endfunction

	// Any byte that ends a number; with plain set, also no blank or sign
	function automatic logic [7:0] pick_nonhex(input bit plain);
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (hex_nibble(c) < 16 || c == CH_CR || c == CH_LF ||
			(plain && (c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF ||
			c == CH_PLUS || c == CH_MINUS)));
		return c;
	endfunction

	// Any byte that stays inside a size line and counts toward its length
	function automatic logic [7:0] pick_text();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_CR || c == CH_LF);
		return c;
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			rx_pending.push_back(s[i]);
	endfunction

	function automatic void push_payload(input int n);
		repeat (n)
			rx_pending.push_back(8'($urandom_range(0, 255)));
	endfunction

	// Emit the line buffer with stray CRs sprinkled in, then the line end
	function automatic void flush_line(input bit with_cr);
		foreach (line_buf[i]) begin
			if ($urandom_range(0, 9) == 0)
				rx_pending.push_back(CH_CR);
			rx_pending.push_back(line_buf[i]);
		end
		if (with_cr)
			rx_pending.push_back(CH_CR);
		rx_pending.push_back(CH_LF);
		line_buf.delete();
	endfunction

	// Size line with random blanks, sign, prefix, leading zeros, case and
	// extension text; never longer than the line limit allows
	function automatic void push_size_line(input logic [SIZE_BITS-1:0] sz);
		int n_dig;
		int room;
		line_buf.delete();
		if ($urandom_range(0, 1))
			repeat ($urandom_range(1, 3))
				line_buf.push_back(pick_blank());
		if ($urandom_range(0, 3) == 0)
			line_buf.push_back(CH_PLUS);
		if ($urandom_range(0, 2) == 0) begin
			line_buf.push_back(CH_ZERO);
			line_buf.push_back($urandom_range(0, 1) ? CH_X_UP : CH_X_LO);
			repeat ($urandom_range(0, 2))
				line_buf.push_back(CH_ZERO);
		end else if ($urandom_range(0, 3) == 0) begin
			line_buf.push_back(CH_ZERO);
		end
		n_dig = 1;
		while (n_dig < SIZE_BITS / 4 && (sz >> (4 * n_dig)) != '0)
			n_dig++;
		for (int k = n_dig - 1; k >= 0; k--)
			line_buf.push_back(hex_char(sz[4*k +: 4], 1'($urandom_range(0, 1))));
		room = LINE_LIMIT - 1 - line_buf.size();
		if (room > 0 && $urandom_range(0, 2) == 0) begin
			// chunk extension: starts with a non-hex byte, then anything
			line_buf.push_back(pick_nonhex(1'b0));
			room--;
			repeat (($urandom_range(0, 7) == 0) ? room : $urandom_range(0, room))
				line_buf.push_back(pick_text());
		end
		flush_line($urandom_range(0, 4) != 0);
	endfunction

	function automatic void push_chunk(input logic [SIZE_BITS-1:0] sz);
		push_size_line(sz);
		push_payload(sz);
		push_text("\r\n");
	endfunction

	function automatic int idle_pct(input int accepted, input bit sender);
		if (accepted < PHASE_B)
			return sender ? 27 : 75;
		if (accepted < PHASE_C)
			return sender ? 75 : 27;
		return 0;
	endfunction

	function automatic void check_field(input string what, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t  %s mismatch: expected %0h, actual %0h", $time, what, want, got);
			error_count++;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Driver: offer bytes from rx_pending, hold a stalled transaction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : send_proc
		bit took;
		int accepted_now;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			took         = in_valid && !in_stall;
			accepted_now = sent_count + int'(took);
			if (took) begin
				void'(rx_pending.pop_front());
				sent_count <= accepted_now;
			end
			// A stalled transaction keeps valid and byte untouched.
			// Otherwise drop valid when out of bytes, while waiting for the
			// decoder to drain at the change to PHASE_B, or on a random idle cycle.
			if (!in_valid || took) begin
				if (rx_pending.size() == 0 ||
						(accepted_now == PHASE_B && results_seen != accepted_now) ||
						$urandom_range(0, 99) < idle_pct(accepted_now, 1'b1)) begin
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					rx_byte  <= rx_pending[0];
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: random stall, plus one long hold-off in the busy phase
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && sent_count >= PHASE_C + 20) begin
			// hold off long enough that the decoder has to stall its input
			out_stall <= 1'b1;
			hold_left <= LONG_HOLD;
			hold_done <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < idle_pct(sent_count, 1'b0));
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: check each result transaction, then predict from each accepted
	// input transaction of the same edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : watch_proc
		decoded_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (predicted_out.size() == 0) begin
					$display("%0t  result with no transaction pending: byte %0h valid %0b last %0b status %0d",
						$time, payload_byte, payload_valid, chunk_last, status);
					error_count++;
				end else begin
					want = predicted_out.pop_front();
					check_field("payload_byte", want.data, payload_byte);
					check_field("payload_valid", 8'(want.valid), 8'(payload_valid));
					check_field("chunk_last", 8'(want.last), 8'(chunk_last));
					check_field("status", 8'(want.status), 8'(status));
					payload_total += int'(want.valid);
					chunk_total   += int'(want.last);
				end
				results_seen <= results_seen + 1;
			end
			if (in_valid && !in_stall)
				predicted_out.push_back(decode_rx_byte(rx_byte));
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin : stim_proc
		logic [SIZE_BITS-1:0] sz;

		// Directed: NUL and all-ones payload bytes, every blank kind, plus sign
		// with 0x prefix, and a NUL ending the number ahead of extension text.
		push_text("1\r\n");
		rx_pending.push_back(8'h00);
		push_text("\r\n");
		rx_pending.push_back(CH_SP);
		rx_pending.push_back(CH_TAB);
		rx_pending.push_back(CH_VT);
		rx_pending.push_back(CH_FF);
		push_text("+0x2\r\n");
		rx_pending.push_back(8'hFF);
		rx_pending.push_back(8'h80);
		push_text("\r\n1");
		rx_pending.push_back(8'h00);
		push_text("g\n");
		rx_pending.push_back(8'h7F);
		push_text("\r\n");

		// Random well-formed chunks, mostly short ones
		while (rx_pending.size() < BODY_BYTES) begin
			sz = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
			push_chunk(sz);
		end

		// Close the body with one finishing or error case
		body_end = body_end_t'($urandom_range(0, N_BODY_ENDS - 1));
		case (body_end)
			END_ZERO_SIZE: begin
				push_size_line('0);
			end
			END_PREFIX_ONLY: begin
				line_buf.push_back(CH_ZERO);
				line_buf.push_back($urandom_range(0, 1) ? CH_X_UP : CH_X_LO);
				line_buf.push_back(pick_nonhex(1'b0));
				flush_line(1'b1);
			end
			END_MINUS_SIGN: begin
				if ($urandom_range(0, 1))
					line_buf.push_back(pick_blank());
				line_buf.push_back(CH_MINUS);
				if ($urandom_range(0, 1))
					line_buf.push_back(hex_char(4'($urandom_range(1, 15)), 1'b0));
				flush_line(1'b1);
			end
			END_NO_DIGITS: begin
				if ($urandom_range(0, 1))
					line_buf.push_back(pick_nonhex(1'b1));
				flush_line(1'b1);
			end
			END_BLANK_AFTER_SIGN: begin
				line_buf.push_back(CH_PLUS);
				line_buf.push_back(pick_blank());
				line_buf.push_back(hex_char(4'($urandom_range(1, 15)), 1'b1));
				flush_line(1'b1);
			end
			END_LONG_LINE: begin
				line_buf.push_back(hex_char(4'd1, 1'b0));
				repeat (LINE_LIMIT - 1)
					line_buf.push_back(pick_text());
				flush_line(1'b0);
			end
			END_BAD_TRAILER: begin
				sz = $urandom_range(1, 8);
				push_size_line(sz);
				push_payload(sz);
				if ($urandom_range(0, 1)) begin
					rx_pending.push_back(pick_nonhex(1'b1));
				end else begin
					rx_pending.push_back(CH_CR);
					rx_pending.push_back(pick_nonhex(1'b1));
				end
			end
			default: begin
				// size far past 32 bits: it saturates and the chunk never ends
				line_buf.push_back(hex_char(4'd1, 1'b0));
				repeat ($urandom_range(8, 12))
					line_buf.push_back(hex_char(4'($urandom_range(0, 15)),
						1'($urandom_range(0, 1))));
				flush_line(1'b1);
				push_payload(40);
			end
		endcase
		// bytes after the close must leave the sticky status alone
		push_payload(4);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (rx_pending.size() != 0 || in_valid || results_seen != sent_count)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (predicted_out.size() != 0)
			$display("%0t  %0d predicted results never arrived", $time, predicted_out.size());
		$display("Covered %0d received bytes: %0d payload bytes in %0d chunks decoded,",
			sent_count, payload_total, chunk_total);
		$display("body closed by %s, final status %0d", body_end.name(), body_status);
		if (error_count == 0 && predicted_out.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_TIME);
		$display("%0t  timeout: %0d bytes accepted, %0d results seen", $time, sent_count,
			results_seen);
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
src/hcbd_pkg.sv
src/http_chunked_body_decoder.sv
dv/http_chunked_body_decoder_tb.sv
